/* design/assert_macros.svh */
// Assertion helpers shared by the design modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside of reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The condition must never be seen outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* design/dntf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dntf_pkg
// Types, codes and constants shared by the drum note trigger filter.
// ----------------------------------------------------------------------------
package dntf_pkg;

  localparam int unsigned MAP_ENTRIES_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned PAD_SLOTS       = 8;
  localparam int unsigned PAD_W           = 3;
  localparam int unsigned Q_DEPTH         = 2;

  localparam logic [7:0] STATUS_NOTE_ON = 8'd144;
  localparam logic [7:0] STATUS_DRUM_ON = 8'd153;

  typedef enum logic [1:0] {
    OP_NOTE = 2'd0,
    OP_LOAD = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_DYN_THRESH  = 2'd0,
    CFG_SHOW_DYN    = 2'd1,
    CFG_LANE_LAYOUT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_NOTE = 3'd0,  // qualifying note message, walk the map
    CMD_TIME = 3'd1,  // note message that only advances time
    CMD_LOAD = 3'd2,
    CMD_READ = 3'd3,
    CMD_NOP  = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    logic [6:0]       dyn_thresh;
    logic             show_dyn;
    logic [23:0]      lane_layout;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    dyn_thresh:  7'd100,
    show_dyn:    1'b1,
    lane_layout: 24'hFAC688
  };

  typedef struct packed {
    logic [6:0]       note;
    logic [7:0]       vmin;
    logic [31:0]      hold;
    logic [PAD_W-1:0] pad;
  } map_entry_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [6:0]       msg_note;
    logic [7:0]       velocity;
    logic [31:0]      delta;
    logic [3:0]       entry_index;
    map_entry_t       ent;
    logic             entry_enable;
  } cmd_t;

  typedef struct packed {
    logic             hit_accepted;
    logic             note_matched;
    logic [PAD_W-1:0] pad_slot;
    logic [2:0]       display_lane;
    logic             ghost_note;
    logic             dim_flag;
    logic [31:0]      pad_hits;
    logic [31:0]      pad_ghosts;
  } res_t;

endpackage

/* design/dntf_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dntf channel interfaces
// Ready/valid channels for note items, results and configuration writes.
// ----------------------------------------------------------------------------
interface dntf_note_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  status_byte;
  logic        full_message;
  logic [7:0]  note_number;
  logic [7:0]  velocity;
  logic [31:0] delta_time;
  logic [3:0]  entry_index;
  logic [6:0]  entry_note;
  logic [7:0]  entry_velocity_threshold;
  logic [31:0] entry_hold_ticks;
  logic [2:0]  pad_select;
  logic        entry_enable;

  modport source (
    output valid, operation, status_byte, full_message, note_number, velocity,
           delta_time, entry_index, entry_note, entry_velocity_threshold,
           entry_hold_ticks, pad_select, entry_enable,
    input  ready
  );
  modport sink (
    input  valid, operation, status_byte, full_message, note_number, velocity,
           delta_time, entry_index, entry_note, entry_velocity_threshold,
           entry_hold_ticks, pad_select, entry_enable,
    output ready
  );
endinterface

interface dntf_result_if;
  logic        valid;
  logic        ready;
  logic        hit_accepted;
  logic        note_matched;
  logic [2:0]  pad_slot;
  logic [2:0]  display_lane;
  logic        ghost_note;
  logic        dim_flag;
  logic [31:0] pad_hits;
  logic [31:0] pad_ghosts;

  modport source (
    output valid, hit_accepted, note_matched, pad_slot, display_lane,
           ghost_note, dim_flag, pad_hits, pad_ghosts,
    input  ready
  );
  modport sink (
    input  valid, hit_accepted, note_matched, pad_slot, display_lane,
           ghost_note, dim_flag, pad_hits, pad_ghosts,
    output ready
  );
endinterface

interface dntf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

/* design/dntf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dntf_front
// Accepts input items, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module dntf_front #(
  parameter int unsigned MAP_ENTRIES = dntf_pkg::MAP_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dntf_note_if.sink     note_i,
  output dntf_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import dntf_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             cmd_in;
  cmd_t             q_mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  always_comb begin
    cmd_in              = '0;
    cmd_in.msg_note     = note_i.note_number[6:0];
    cmd_in.velocity     = note_i.velocity;
    cmd_in.delta        = note_i.delta_time;
    cmd_in.entry_index  = note_i.entry_index;
    cmd_in.ent.note     = note_i.entry_note;
    cmd_in.ent.vmin     = note_i.entry_velocity_threshold;
    cmd_in.ent.hold     = note_i.entry_hold_ticks;
    cmd_in.ent.pad      = note_i.pad_select;
    cmd_in.entry_enable = note_i.entry_enable;
    case (note_i.operation)
      OP_NOTE: begin
        // A note number above 127 can never match an entry.
        if (note_i.full_message && !note_i.note_number[7] &&
            (note_i.status_byte inside {STATUS_NOTE_ON, STATUS_DRUM_ON})) begin
          cmd_in.kind = CMD_NOTE;
        end else begin
          cmd_in.kind = CMD_TIME;
        end
      end
      OP_LOAD: begin
        cmd_in.kind = (32'(note_i.entry_index) < MAP_ENTRIES) ? CMD_LOAD : CMD_NOP;
      end
      OP_READ: cmd_in.kind = CMD_READ;
      default: cmd_in.kind = CMD_NOP;
    endcase
  end

  assign note_i.ready = (count_q != CNT_W'(Q_DEPTH));
  assign push         = note_i.valid && note_i.ready;
  assign cmd_valid_o  = (count_q != '0);
  assign pop          = cmd_valid_o && cmd_ready_i;
  assign cmd_o        = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_q_bound, count_q > CNT_W'(Q_DEPTH), "command queue count overflow")
  `ASSERT_AT(a_q_push, push && !pop |=> count_q == $past(count_q) + 1'b1, "push lost")
  `ASSERT_NEVER(a_q_empty_ptr, count_q == '0 && wr_ptr_q != rd_ptr_q, "queue pointers diverged")

endmodule

/* design/dntf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dntf_back
// Executes queued commands: walks the mapping memory, qualifies hits,
// updates pad counters and registers one result per command.
// ----------------------------------------------------------------------------
module dntf_back #(
  parameter int unsigned MAP_ENTRIES = dntf_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned TIME_BITS   = dntf_pkg::TIME_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dntf_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  dntf_pkg::cfg_t cfg_i,
  dntf_result_if.source  result_o
);
  import dntf_pkg::*;

  localparam int unsigned IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WALK   = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction

  state_e               state_q, state_d;
  cmd_t                 cmd_q;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [TIME_BITS:0]   time_sum;
  logic [TIME_BITS-1:0] time_adv;
  logic [IDX_W-1:0]     issue_q, issue_d;
  logic                 issue_live_q, issue_live_d;
  logic                 chk_valid_q, chk_valid_d;
  logic [IDX_W-1:0]     chk_idx_q;
  logic [IDX_W-1:0]     hit_idx_q;
  map_entry_t           ent_q;
  logic [TIME_BITS-1:0] last_q;
  logic [TIME_BITS-1:0] since_q, since_d;
  logic [MAP_ENTRIES-1:0] valid_q;

  map_entry_t           ent_mem  [MAP_ENTRIES];
  logic [TIME_BITS-1:0] last_mem [MAP_ENTRIES];
  map_entry_t           rd_ent_q;
  logic [TIME_BITS-1:0] rd_last_q;
  logic                 ent_we, last_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [TIME_BITS-1:0] last_wdata;
  logic [IDX_W-1:0]     load_addr;

  logic [31:0]          hit_cnt_q   [PAD_SLOTS];
  logic [31:0]          ghost_cnt_q [PAD_SLOTS];
  logic [PAD_W-1:0]     cnt_idx;
  logic [31:0]          hit_new, ghost_new;
  logic [2:0]           lane;
  logic                 ghost;
  logic                 cnt_we;

  logic                 start, match, accept;
  res_t                 res_d, res_q;
  logic                 res_load;
  logic                 out_valid_q;

  assign cmd_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign start       = cmd_valid_i && cmd_ready_o;

  // Saturating time accumulator update.
  assign time_sum  = {1'b0, time_q} + (TIME_BITS + 1)'(cmd_i.delta);
  assign time_adv  = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
  assign load_addr = IDX_W'(cmd_i.entry_index);

  assign match  = valid_q[chk_idx_q] && (rd_ent_q.note == cmd_q.msg_note);
  assign since_d = (time_q >= last_q) ? time_q - last_q : '0;
  assign accept = (cmd_q.velocity >= ent_q.vmin) && (since_q >= TIME_BITS'(ent_q.hold));

  assign cnt_idx   = (state_q == ST_UPDATE) ? ent_q.pad : cmd_i.ent.pad;
  assign lane      = 3'(cfg_i.lane_layout >> (5'(cnt_idx) * 5'd3));
  assign ghost     = cmd_q.velocity < {1'b0, cfg_i.dyn_thresh};
  assign hit_new   = sat_inc(hit_cnt_q[cnt_idx]);
  assign ghost_new = ghost ? sat_inc(ghost_cnt_q[cnt_idx]) : ghost_cnt_q[cnt_idx];

  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    issue_d      = issue_q;
    issue_live_d = issue_live_q;
    chk_valid_d  = 1'b0;
    ent_we       = 1'b0;
    last_we      = 1'b0;
    mem_waddr    = load_addr;
    last_wdata   = '0;
    cnt_we       = 1'b0;
    res_d        = '0;
    res_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.kind)
            CMD_NOTE: begin
              time_d       = time_adv;
              issue_d      = '0;
              issue_live_d = 1'b1;
              state_d      = ST_WALK;
            end
            CMD_TIME: begin
              time_d   = time_adv;
              res_load = 1'b1;
            end
            CMD_LOAD: begin
              ent_we   = 1'b1;
              last_we  = 1'b1;
              res_load = 1'b1;
            end
            CMD_READ: begin
              res_d.pad_slot     = cmd_i.ent.pad;
              res_d.display_lane = lane;
              res_d.pad_hits     = hit_cnt_q[cnt_idx];
              res_d.pad_ghosts   = ghost_cnt_q[cnt_idx];
              res_load           = 1'b1;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        // One entry read is issued per cycle; its data is checked in the cycle after.
        chk_valid_d = issue_live_q;
        if (issue_live_q) begin
          if (issue_q == LAST_IDX) begin
            issue_live_d = 1'b0;
          end else begin
            issue_d = issue_q + 1'b1;
          end
        end
        if (chk_valid_q && match) begin
          issue_live_d = 1'b0;
          state_d      = ST_CHECK;
        end else if (chk_valid_q && (chk_idx_q == LAST_IDX)) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (accept) begin
          last_we    = 1'b1;
          mem_waddr  = hit_idx_q;
          last_wdata = time_q;
          state_d    = ST_UPDATE;
        end else begin
          res_d.note_matched = 1'b1;
          res_load           = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        cnt_we             = 1'b1;
        res_d.hit_accepted = 1'b1;
        res_d.note_matched = 1'b1;
        res_d.pad_slot     = ent_q.pad;
        res_d.display_lane = lane;
        res_d.ghost_note   = ghost;
        res_d.dim_flag     = ghost && cfg_i.show_dyn;
        res_d.pad_hits     = hit_new;
        res_d.pad_ghosts   = ghost_new;
        res_load           = 1'b1;
        state_d            = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_q       <= '0;
      issue_q      <= '0;
      issue_live_q <= 1'b0;
      chk_valid_q  <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < PAD_SLOTS; i++) begin
        hit_cnt_q[i]   <= '0;
        ghost_cnt_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      issue_q      <= issue_d;
      issue_live_q <= issue_live_d;
      chk_valid_q  <= chk_valid_d;
      if (ent_we) begin
        valid_q[mem_waddr] <= cmd_i.entry_enable;
      end
      if (cnt_we) begin
        hit_cnt_q[cnt_idx]   <= hit_new;
        ghost_cnt_q[cnt_idx] <= ghost_new;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= cmd_i;
    end
    chk_idx_q <= issue_q;
    if (state_q == ST_WALK && chk_valid_q && match) begin
      ent_q     <= rd_ent_q;
      last_q    <= rd_last_q;
      hit_idx_q <= chk_idx_q;
    end
    since_q <= since_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Mapping memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[mem_waddr] <= cmd_i.ent;
    end
    if (last_we) begin
      last_mem[mem_waddr] <= last_wdata;
    end
    rd_ent_q  <= ent_mem[issue_q];
    rd_last_q <= last_mem[issue_q];
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.hit_accepted = res_q.hit_accepted;
  assign result_o.note_matched = res_q.note_matched;
  assign result_o.pad_slot     = res_q.pad_slot;
  assign result_o.display_lane = res_q.display_lane;
  assign result_o.ghost_note   = res_q.ghost_note;
  assign result_o.dim_flag     = res_q.dim_flag;
  assign result_o.pad_hits     = res_q.pad_hits;
  assign result_o.pad_ghosts   = res_q.pad_ghosts;

`include "assert_macros.svh"

  `ASSERT_NEVER(a_res_overwrite, res_load && out_valid_q, "result register overwritten")
  `ASSERT_NEVER(a_dim_ghost, out_valid_q && res_q.dim_flag && !res_q.ghost_note, "dim without ghost")
  `ASSERT_AT(a_time_mono, 1'b1 |=> time_q >= $past(time_q), "time accumulator went back")

endmodule

/* design/drum_note_trigger_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_note_trigger_filter
// Qualifies drum-pad note messages against a table of mapping entries.
// ----------------------------------------------------------------------------
// A qualifying note message (complete, status 144 or 153, note number below
// 128) walks the mapping memory one entry per cycle until the first valid
// matching entry. The walk goes through the single read port of the mapping
// memory, and that sets the timing. After a match, the CHECK, DECIDE and
// UPDATE states qualify the hit and update the pad counters; a rejected hit
// ends in DECIDE. Loads, counter reads and other note messages register their
// result straight from the idle state. Results sit in an output register, and
// a waiting result holds the back end. A two-deep command queue keeps
// accepting items in the meantime, until it is full.
module drum_note_trigger_filter #(
  parameter int unsigned MAP_ENTRIES = dntf_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned TIME_BITS   = dntf_pkg::TIME_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dntf_note_if.sink     note_i,
  dntf_result_if.source result_o,
  dntf_cfg_if.sink      cfg_i
);
  import dntf_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DYN_THRESH:  cfg_q.dyn_thresh  <= cfg_i.wdata[6:0];
        CFG_SHOW_DYN:    cfg_q.show_dyn    <= cfg_i.wdata[0];
        CFG_LANE_LAYOUT: cfg_q.lane_layout <= cfg_i.wdata;
        default: begin
        end
      endcase
    end
  end

  dntf_front #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .note_i      (note_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  dntf_back #(
    .MAP_ENTRIES(MAP_ENTRIES),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cfg_i       (cfg_q),
    .result_o    (result_o)
  );

endmodule

/* bench/drum_note_trigger_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_note_trigger_filter_tb
// Drives note, load and counter-read items into the trigger filter, predicts
// every result from a local copy of the mapping table, the time accumulator
// and the pad counters, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module drum_note_trigger_filter_tb;
  import dntf_pkg::*;

  localparam int unsigned MAP_N        = MAP_ENTRIES_DEF;
  localparam int unsigned TW           = TIME_BITS_DEF;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned LIMIT_CYC    = 2_000_000;
  localparam int unsigned REPORT_MAX   = 200;
  localparam int unsigned CHUNKS       = 8;
  localparam int unsigned CHUNK_ITEMS  = 90;
  // Back-to-back note messages that each carry the largest time step.
  localparam int unsigned BIG_DT_ITEMS = 40;

  typedef struct {
    op_e         op;
    logic [7:0]  status;
    logic        full;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [31:0] delta;
    logic [3:0]  idx;
    logic [6:0]  e_note;
    logic [7:0]  e_vmin;
    logic [31:0] e_hold;
    logic [2:0]  pad;
    logic        en;
  } trig_item_t;

  logic clk_i;
  logic rst_ni;

  dntf_note_if   note_if ();
  dntf_result_if result_if ();
  dntf_cfg_if    cfg_if ();

  drum_note_trigger_filter i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .note_i   (note_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // Local copy of the filter state.
  cfg_t        cfg_model = CFG_RST;
  bit [6:0]    tbl_note  [MAP_N];
  bit [7:0]    tbl_vmin  [MAP_N];
  bit [31:0]   tbl_hold  [MAP_N];
  bit [2:0]    tbl_pad   [MAP_N];
  bit          tbl_valid [MAP_N];
  bit [TW-1:0] tbl_last  [MAP_N];
  bit [TW-1:0] now_us;
  bit [31:0]   pad_hits   [PAD_SLOTS];
  bit [31:0]   pad_ghosts [PAD_SLOTS];

  trig_item_t  msg_q[$];
  res_t        outcome_q[$];

  bit          in_fire;
  bit          res_fire;
  bit          cfg_fire;
  bit          no_idle;
  int unsigned msg_gap;
  int unsigned res_stall;
  int unsigned cycle_cnt;
  int unsigned errors;
  int unsigned reports;
  int unsigned n_note, n_load, n_read, n_hit, n_reject, n_ghost, n_checked;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Appends one item to the tail of the pending queue.
  function automatic void queue_msg(input trig_item_t it);
    msg_q.insert(msg_q.size(), it);
  endfunction

  // Computes the result of one item and advances the local state.
  function automatic res_t trigger_outcome(input trig_item_t it);
    res_t      r;
    bit [TW:0] sum;
    bit [TW-1:0] since;
    bit [2:0]  p;
    bit        ghost;
    bit        found;
    r = '0;
    found = 1'b0;
    case (it.op)
      OP_NOTE: begin
        sum = now_us + it.delta;
        now_us = sum[TW] ? '1 : sum[TW-1:0];
        if (it.full && (it.status == STATUS_NOTE_ON || it.status == STATUS_DRUM_ON)) begin
          for (int k = 0; k < MAP_N; k++) begin
            if (!found && tbl_valid[k] && {1'b0, tbl_note[k]} == it.note) begin
              found = 1'b1;
              r.note_matched = 1'b1;
              since = (now_us >= tbl_last[k]) ? now_us - tbl_last[k] : '0;
              if (it.vel >= tbl_vmin[k] && since >= tbl_hold[k]) begin
                p = tbl_pad[k];
                ghost = it.vel < {1'b0, cfg_model.dyn_thresh};
                tbl_last[k] = now_us;
                if (pad_hits[p] != '1) pad_hits[p]++;
                if (ghost && pad_ghosts[p] != '1) pad_ghosts[p]++;
                r.hit_accepted = 1'b1;
                r.pad_slot     = p;
                r.display_lane = cfg_model.lane_layout[3*p +: 3];
                r.ghost_note   = ghost;
                r.dim_flag     = ghost && cfg_model.show_dyn;
                r.pad_hits     = pad_hits[p];
                r.pad_ghosts   = pad_ghosts[p];
              end
            end
          end
        end
      end
      OP_LOAD: begin
        if (it.idx < MAP_N) begin
          tbl_note[it.idx]  = it.e_note;
          tbl_vmin[it.idx]  = it.e_vmin;
          tbl_hold[it.idx]  = it.e_hold;
          tbl_pad[it.idx]   = it.pad;
          tbl_valid[it.idx] = it.en;
          tbl_last[it.idx]  = '0;
        end
      end
      OP_READ: begin
        r.pad_slot     = it.pad;
        r.display_lane = cfg_model.lane_layout[3*it.pad +: 3];
        r.pad_hits     = pad_hits[it.pad];
        r.pad_ghosts   = pad_ghosts[it.pad];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Fields that the operation does not use carry random values.
  function automatic trig_item_t rand_fill();
    trig_item_t it;
    it.op     = OP_NOTE;
    it.status = 8'($urandom);
    it.full   = 1'($urandom);
    it.note   = 8'($urandom);
    it.vel    = 8'($urandom);
    it.delta  = $urandom;
    it.idx    = 4'($urandom);
    it.e_note = 7'($urandom);
    it.e_vmin = 8'($urandom);
    it.e_hold = $urandom;
    it.pad    = 3'($urandom);
    it.en     = 1'($urandom);
    return it;
  endfunction

  function automatic trig_item_t note_msg(input logic [7:0] st, input logic full,
                                          input logic [7:0] nt, input logic [7:0] vel,
                                          input logic [31:0] dt);
    trig_item_t it;
    it = rand_fill();
    it.op = OP_NOTE;
    it.status = st;
    it.full = full;
    it.note = nt;
    it.vel = vel;
    it.delta = dt;
    return it;
  endfunction

  function automatic trig_item_t load_msg(input logic [3:0] idx, input logic [6:0] nt,
                                          input logic [7:0] vmin, input logic [31:0] hold,
                                          input logic [2:0] pad, input logic en);
    trig_item_t it;
    it = rand_fill();
    it.op = OP_LOAD;
    it.idx = idx;
    it.e_note = nt;
    it.e_vmin = vmin;
    it.e_hold = hold;
    it.pad = pad;
    it.en = en;
    return it;
  endfunction

  function automatic trig_item_t read_msg(input logic [2:0] pad);
    trig_item_t it;
    it = rand_fill();
    it.op = OP_READ;
    it.pad = pad;
    return it;
  endfunction

  // Mostly note messages aimed at a small band of notes so that entries
  // collide, hits repeat within hold times and counters grow.
  function automatic trig_item_t random_msg();
    int unsigned roll;
    logic [7:0]  st;
    logic [7:0]  nt;
    logic [7:0]  vmin;
    logic [31:0] val;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      nt = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 47)) : 8'($urandom);
      case ($urandom_range(0, 4))
        0:       vmin = 8'd0;
        1:       vmin = 8'($urandom);
        default: vmin = 8'($urandom_range(0, 100));
      endcase
      case ($urandom_range(0, 3))
        0:       val = 32'd0;
        1:       val = $urandom;
        default: val = $urandom_range(0, 3000);
      endcase
      return load_msg(4'($urandom), nt[6:0], vmin, val, 3'($urandom),
                      $urandom_range(0, 9) != 0);
    end
    if (roll < 22) return read_msg(3'($urandom));
    roll = $urandom_range(0, 99);
    st = (roll < 45) ? STATUS_NOTE_ON : (roll < 90) ? STATUS_DRUM_ON : 8'($urandom);
    nt = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(32, 47)) : 8'($urandom);
    roll = $urandom_range(0, 9);
    val = (roll < 7) ? $urandom_range(0, 2000) : (roll < 9) ? 32'd0 : $urandom;
    return note_msg(st, $urandom_range(0, 9) != 0, nt, 8'($urandom), val);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (reports < REPORT_MAX)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      reports++;
    end
  endtask

  // Message driver: one transfer at a time, a random gap before each item unless no_idle is set.
  always @(negedge clk_i) begin : drive_msgs
    trig_item_t it;
    bit launch;
    launch = 1'b0;
    if (!rst_ni) begin
      note_if.valid <= 1'b0;
    end else begin
      if (note_if.valid && in_fire) msg_gap = no_idle ? 0 : $urandom_range(0, 19);
      if (!note_if.valid || in_fire) begin
        if (msg_gap > 0) begin
          msg_gap--;
        end else if (msg_q.size() > 0) begin
          it = msg_q.pop_front();
          launch = 1'b1;
          note_if.operation                <= it.op;
          note_if.status_byte              <= it.status;
          note_if.full_message             <= it.full;
          note_if.note_number              <= it.note;
          note_if.velocity                 <= it.vel;
          note_if.delta_time               <= it.delta;
          note_if.entry_index              <= it.idx;
          note_if.entry_note               <= it.e_note;
          note_if.entry_velocity_threshold <= it.e_vmin;
          note_if.entry_hold_ticks         <= it.e_hold;
          note_if.pad_select               <= it.pad;
          note_if.entry_enable             <= it.en;
        end
        note_if.valid <= launch;
      end
    end
  end

  // Result receiver: stalls a random number of cycles after each transfer, unless no_idle is set.
  always @(negedge clk_i) begin : accept_results
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (res_fire) res_stall = no_idle ? 0 : $urandom_range(0, 19);
      else if (res_stall > 0) res_stall--;
      result_if.ready <= (res_stall == 0);
    end
  end

  // Monitor: predicts on every accepted item and checks every result.
  always @(posedge clk_i) begin : watch
    trig_item_t seen;
    res_t want;
    res_t got;
    in_fire  <= rst_ni && note_if.valid && note_if.ready;
    res_fire <= rst_ni && result_if.valid && result_if.ready;
    cfg_fire <= rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_DYN_THRESH:  cfg_model.dyn_thresh  = cfg_if.wdata[6:0];
        CFG_SHOW_DYN:    cfg_model.show_dyn    = cfg_if.wdata[0];
        CFG_LANE_LAYOUT: cfg_model.lane_layout = cfg_if.wdata;
        default: ;
      endcase
    end
    if (rst_ni && note_if.valid && note_if.ready) begin
      seen.op     = op_e'(note_if.operation);
      seen.status = note_if.status_byte;
      seen.full   = note_if.full_message;
      seen.note   = note_if.note_number;
      seen.vel    = note_if.velocity;
      seen.delta  = note_if.delta_time;
      seen.idx    = note_if.entry_index;
      seen.e_note = note_if.entry_note;
      seen.e_vmin = note_if.entry_velocity_threshold;
      seen.e_hold = note_if.entry_hold_ticks;
      seen.pad    = note_if.pad_select;
      seen.en     = note_if.entry_enable;
      case (seen.op)
        OP_NOTE: n_note++;
        OP_LOAD: n_load++;
        default: n_read++;
      endcase
      outcome_q.insert(outcome_q.size(), trigger_outcome(seen));
    end
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.hit_accepted = result_if.hit_accepted;
      got.note_matched = result_if.note_matched;
      got.pad_slot     = result_if.pad_slot;
      got.display_lane = result_if.display_lane;
      got.ghost_note   = result_if.ghost_note;
      got.dim_flag     = result_if.dim_flag;
      got.pad_hits     = result_if.pad_hits;
      got.pad_ghosts   = result_if.pad_ghosts;
      if (outcome_q.size() == 0) begin
        errors++;
        if (reports < REPORT_MAX)
          $display("%0t ns: result with nothing outstanding, expected none, actual %h",
                   $time, got);
        reports++;
      end else begin
        want = outcome_q.pop_front();
        n_checked++;
        if (want.hit_accepted) n_hit++;
        else if (want.note_matched) n_reject++;
        if (want.ghost_note) n_ghost++;
        check_field("hit_accepted", want.hit_accepted, got.hit_accepted);
        check_field("note_matched", want.note_matched, got.note_matched);
        check_field("pad_slot", want.pad_slot, got.pad_slot);
        check_field("display_lane", want.display_lane, got.display_lane);
        check_field("ghost_note", want.ghost_note, got.ghost_note);
        check_field("dim_flag", want.dim_flag, got.dim_flag);
        check_field("pad_hits", want.pad_hits, got.pad_hits);
        check_field("pad_ghosts", want.pad_ghosts, got.pad_ghosts);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYC) begin
      $display("%0t ns: run stopped after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, outcome_q.size());
      $display("drum_note_trigger_filter_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_if.valid <= 1'b0;
  endtask

  // Upper data bits beyond each register's width are random.
  task automatic write_all_regs(input logic [6:0] thresh, input logic show,
                                input logic [23:0] layout);
    write_reg(CFG_DYN_THRESH, {17'($urandom), thresh});
    write_reg(CFG_SHOW_DYN, {23'($urandom), show});
    write_reg(CFG_LANE_LAYOUT, layout);
  endtask

  // Waits until every item went in and every result came back, then lets
  // the block settle before anything else happens.
  task automatic settle();
    while (msg_q.size() > 0 || note_if.valid || outcome_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  initial begin : run
    rst_ni = 1'b0;
    no_idle = 1'b0;
    note_if.valid = 1'b0;
    note_if.operation = OP_NOTE;
    note_if.status_byte = '0;
    note_if.full_message = 1'b0;
    note_if.note_number = '0;
    note_if.velocity = '0;
    note_if.delta_time = '0;
    note_if.entry_index = '0;
    note_if.entry_note = '0;
    note_if.entry_velocity_threshold = '0;
    note_if.entry_hold_ticks = '0;
    note_if.pad_select = '0;
    note_if.entry_enable = 1'b0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DYN_THRESH;
    cfg_if.wdata = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset register values.
    queue_msg(read_msg(3'd0));
    queue_msg(read_msg(3'd7));
    queue_msg(load_msg(4'd0, 7'd38, 8'd0, 32'd0, 3'd0, 1'b1));
    queue_msg(load_msg(4'd15, 7'd127, 8'd255, 32'hFFFF_FFFF, 3'd7, 1'b1));
    // A second entry for the same note must never be consulted.
    queue_msg(load_msg(4'd1, 7'd38, 8'd0, 32'd0, 3'd1, 1'b1));
    queue_msg(load_msg(4'd2, 7'd36, 8'd0, 32'd0, 3'd2, 1'b0));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd38, 8'd127, 32'd0));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd38, 8'd0, 32'd5));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd38, 8'd99, 32'd1));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd38, 8'd100, 32'd1));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b0, 8'd38, 8'd127, 32'd3));
    queue_msg(note_msg(8'h80, 1'b1, 8'd38, 8'd127, 32'd3));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd36, 8'd127, 32'd0));
    // Note 255 aliases entry 15 in its low bits but must not match.
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd255, 8'd255, 32'd0));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd127, 8'd254, 32'd0));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd127, 8'd255, 32'hFFFF_FFFF));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd127, 8'd255, 32'd0));
    queue_msg(load_msg(4'd3, 7'd40, 8'd10, 32'd1000, 3'd3, 1'b1));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd40, 8'd10, 32'd0));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd40, 8'd200, 32'd999));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd40, 8'd200, 32'd1));
    queue_msg(read_msg(3'd3));
    queue_msg(read_msg(3'd0));
    settle();

    for (int c = 0; c < CHUNKS; c++) begin
      case (c)
        0:       write_all_regs(7'd0, 1'b0, 24'h000000);
        1:       write_all_regs(7'd127, 1'b1, 24'hFFFFFF);
        default: write_all_regs(7'($urandom), 1'($urandom), 24'($urandom));
      endcase
      no_idle = (c % 3 == 2);
      for (int n = 0; n < CHUNK_ITEMS; n++) queue_msg(random_msg());
      settle();
    end

    // Push the time accumulator far ahead with incomplete or non-qualifying
    // messages, back to back.
    write_all_regs(7'd64, 1'b1, 24'($urandom));
    no_idle = 1'b1;
    for (int n = 0; n < BIG_DT_ITEMS; n++) begin
      if (n % 2 == 0)
        queue_msg(note_msg(STATUS_DRUM_ON, 1'b0, 8'($urandom), 8'($urandom),
                           32'hFFFF_FFFF));
      else
        queue_msg(note_msg(8'($urandom_range(0, 143)), 1'b1, 8'($urandom),
                           8'($urandom), 32'hFFFF_FFFF));
    end
    settle();

    // Hold times measured against a large time value.
    no_idle = 1'b0;
    queue_msg(load_msg(4'd0, 7'd38, 8'd0, 32'd0, 3'd0, 1'b1));
    queue_msg(load_msg(4'd1, 7'd40, 8'd0, 32'd1000, 3'd3, 1'b1));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd38, 8'd50, 32'hFFFF_FFFF));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd38, 8'd120, 32'd7));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd40, 8'd127, 32'd0));
    queue_msg(note_msg(STATUS_NOTE_ON, 1'b1, 8'd40, 8'd127, 32'hFFFF_FFFF));
    queue_msg(load_msg(4'd1, 7'd40, 8'd0, 32'd1000, 3'd3, 1'b1));
    queue_msg(note_msg(STATUS_DRUM_ON, 1'b1, 8'd40, 8'd30, 32'd0));
    queue_msg(read_msg(3'd0));
    queue_msg(read_msg(3'd3));
    settle();

    $display("Checked %0d results: %0d note messages, %0d loads, %0d counter reads.",
             n_checked, n_note, n_load, n_read);
    $display("Hits accepted %0d (ghost %0d), matched but rejected %0d, mismatches %0d.",
             n_hit, n_ghost, n_reject, errors);
    if (errors == 0) begin
      $display("drum_note_trigger_filter_tb passed");
    end else begin
      $display("drum_note_trigger_filter_tb failed");
    end
    $finish;
  end

endmodule
